@@ hw/rtl/neighbour_mask_tile_classifier_macros.svh @@
// assertion macros of the tile classifier rtl
// no dependencies; the top level includes this file by name
`ifndef NEIGHBOUR_MASK_TILE_CLASSIFIER_MACROS_SVH
`define NEIGHBOUR_MASK_TILE_CLASSIFIER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NTC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define NTC_ASSERT(label, prop, msg)
`define NTC_NEVER(label, cond, msg)
`endif
`endif

@@ hw/rtl/ntc_pkg.sv @@
// types, constants and lookup functions of the tile classifier
// no dependencies; used by the top level and the seed unit
package ntc_pkg;

  localparam int MAX_WIDTH   = 32;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int STORE_DEPTH = 3 * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int GW_W       = 6;
  localparam int GH_W       = 13;
  localparam int ROW_W      = 12;
  localparam int SEED_W     = 32;
  localparam int TEX_W      = 6;
  localparam int CODE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int SQ_W       = 27;
  localparam int SEED_STEPS = 32;
  localparam int STEP_W     = $clog2(SEED_STEPS);

  localparam int NB_READS = 9;
  localparam int NB_W     = 4;

  localparam logic [GH_W-1:0]   HEIGHT_LIMIT = 13'd4096;
  localparam logic [SEED_W-1:0] SEED_KICK    = 32'd54538;
  localparam logic [CODE_W-1:0] CODE_PLAIN   = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_START_SEED,
    REG_CEIL_COUNT,
    REG_FLOOR_COUNT
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_FLOOR,
    CLS_CEIL,
    CLS_WALL,
    CLS_OTHER
  } cls_e;

  typedef enum logic [1:0] {
    OFS_ZERO,
    OFS_MINUS,
    OFS_PLUS
  } ofs_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PUT
  } st_e;

  // which cell of the pending list is being emitted
  typedef enum logic [1:0] {
    PH_PREV_LEFT,
    PH_PREV_CUR,
    PH_FLUSH
  } phase_e;

  typedef struct packed {
    logic              done;
    logic [TEX_W-1:0]  floor_tex;
    logic [TEX_W-1:0]  ceil_tex;
    logic [SEED_W-1:0] next_seed;
  } seed_stat_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] list;
  } wall_hit_t;

  function automatic wall_hit_t wall_lookup(input logic [7:0] m);
    wall_hit_t res;
    res.hit = 1'b1;
    case (m) inside
      8'd64, 8'd96, 8'd192, 8'd224:                    res.list = 4'd0;
      8'd2, 8'd3, 8'd6, 8'd7:                          res.list = 4'd1;
      8'd16, 8'd20, 8'd144, 8'd148:                    res.list = 4'd2;
      8'd8, 8'd9, 8'd40, 8'd41:                        res.list = 4'd3;
      8'd128:                                          res.list = 4'd4;
      8'd32:                                           res.list = 4'd5;
      8'd4:                                            res.list = 4'd6;
      8'd1:                                            res.list = 4'd7;
      8'd104, 8'd105, 8'd232, 8'd233,
      8'd72, 8'd73, 8'd200, 8'd201:                    res.list = 4'd8;
      8'd208, 8'd212, 8'd240, 8'd244,
      8'd80, 8'd84, 8'd112, 8'd116:                    res.list = 4'd9;
      8'd11, 8'd15, 8'd43, 8'd47,
      8'd10, 8'd14, 8'd42, 8'd46:                      res.list = 4'd10;
      8'd22, 8'd23, 8'd150, 8'd151,
      8'd18, 8'd19, 8'd146, 8'd147:                    res.list = 4'd11;
      8'd90, 8'd91, 8'd94, 8'd95, 8'd122, 8'd123, 8'd126, 8'd127,
      8'd218, 8'd219, 8'd222, 8'd223, 8'd250, 8'd251, 8'd254, 8'd255:
                                                       res.list = 4'd13;
      default: begin
        res.hit  = 1'b0;
        res.list = 4'd0;
      end
    endcase
    return res;
  endfunction

  // read order: center first, then mask bits 0..7
  function automatic ofs_e nb_row(input logic [NB_W-1:0] k);
    ofs_e r;
    case (k)
      4'd1, 4'd2, 4'd3: r = OFS_MINUS;
      4'd6, 4'd7, 4'd8: r = OFS_PLUS;
      default:          r = OFS_ZERO;
    endcase
    return r;
  endfunction

  function automatic ofs_e nb_col(input logic [NB_W-1:0] k);
    ofs_e c;
    case (k)
      4'd1, 4'd4, 4'd6: c = OFS_MINUS;
      4'd3, 4'd5, 4'd8: c = OFS_PLUS;
      default:          c = OFS_ZERO;
    endcase
    return c;
  endfunction

  // slot of the row that lies b rows above the row in slot s
  function automatic logic [1:0] slot_back(input logic [1:0] s, input logic [1:0] b);
    logic [2:0] t;
    t = {1'b0, s} + 3'd3 - {1'b0, b};
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_base(input logic [1:0] s);
    logic [ADDR_W-1:0] b;
    case (s)
      2'd0:    b = '0;
      2'd1:    b = ADDR_W'(MAX_WIDTH);
      default: b = ADDR_W'(2 * MAX_WIDTH);
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/ntc_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module ntc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ntc_seed.sv @@
// bit-serial seed unit: squares the seed and takes both texture remainders
// depends on ntc_pkg
module ntc_seed (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ntc_pkg::SEED_W-1:0] seed_i,
  input  logic [ntc_pkg::TEX_W-1:0]  ceil_cnt_i,
  input  logic [ntc_pkg::TEX_W-1:0]  floor_cnt_i,
  output ntc_pkg::seed_stat_t        stat_o
);
  import ntc_pkg::*;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [SQ_W-1:0]   mcand_q, mplier_q, acc_q;
  logic [SEED_W-1:0] div_q, seed_q;
  logic [TEX_W-1:0]  remc_q, remf_q;
  logic [SEED_W-1:0] shifted;

  function automatic logic [TEX_W-1:0] rem_step(input logic [TEX_W-1:0] rem,
                                                input logic b,
                                                input logic [TEX_W-1:0] cnt);
    logic [TEX_W:0] r;
    r = {rem, b};
    if (r >= {1'b0, cnt}) begin
      r = r - {1'b0, cnt};
    end
    return r[TEX_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == STEP_W'(SEED_STEPS - 1)) && !start_i;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(SEED_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // low 27 bits of the square are all that survive the shift by five
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      seed_q   <= seed_i;
      mcand_q  <= seed_i[SQ_W-1:0];
      mplier_q <= seed_i[SQ_W-1:0];
      acc_q    <= '0;
      div_q    <= seed_i;
      remc_q   <= '0;
      remf_q   <= '0;
    end else if (busy_q) begin
      acc_q    <= acc_q + (mplier_q[0] ? mcand_q : '0);
      mcand_q  <= {mcand_q[SQ_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[SQ_W-1:1]};
      div_q    <= {div_q[SEED_W-2:0], 1'b0};
      remc_q   <= rem_step(remc_q, div_q[SEED_W-1], ceil_cnt_i);
      remf_q   <= rem_step(remf_q, div_q[SEED_W-1], floor_cnt_i);
    end
  end

  // arithmetic shift right by 15 of the square shifted left by 5
  assign shifted = {{(SEED_W - SQ_W + 10){acc_q[SQ_W-1]}}, acc_q[SQ_W-1:10]};

  assign stat_o.done      = done_q;
  assign stat_o.floor_tex = (floor_cnt_i == '0) ? '0 : remf_q;
  assign stat_o.ceil_tex  = (ceil_cnt_i == '0) ? '0 : remc_q;
  assign stat_o.next_seed = (shifted == seed_q) ? seed_q + SEED_KICK : shifted;

endmodule

@@ hw/rtl/neighbour_mask_tile_classifier.sv @@
// channel    | valid       | stall        | payload
// config     | cfg_we_i    | (none)       | cfg_index_i, cfg_data_i
// cell in    | in_valid_i  | in_stall_o   | cell_class_i
// tile out   | out_valid_o | out_stall_i  | tile_code_o, last_of_run_o, frame_done_o
// each tile word runs the bit-serial seed unit (square and remainders) between start
// and hand-off; neighbor reads of the row store overlap it
// a cell that causes no tile is taken without stalling the input; one cell is in work at a time
// the frame's last cell yields up to the effective grid width + 2 words
// reset loads the geometry defaults and clears the counters; the row store is not cleared
// a stalled output word holds while the next word is already being worked out
// top level of the tile classifier; depends on ntc_pkg, ntc_ram, ntc_seed and the macros
`include "neighbour_mask_tile_classifier_macros.svh"
module neighbour_mask_tile_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ntc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cell_class_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ntc_pkg::CODE_W-1:0]     tile_code_o,
  output logic                           last_of_run_o,
  output logic                           frame_done_o
);
  import ntc_pkg::*;

  logic [GW_W-1:0]   gw_q, ccnt_q, fcnt_q;
  logic [GH_W-1:0]   gh_q;
  logic [SEED_W-1:0] sseed_q, seed_q, seed_d;
  logic [COL_W-1:0]  col_q, c_q, j_q, ec, nb_c;
  logic [ROW_W-1:0]  row_q;
  logic [1:0]        slot_q, eslot_q, nb_back, nb_slot;
  logic              rge1_q, rge2_q, e_pc_q, e_fr_q;
  st_e               state_q, state_d;
  phase_e            phase_q, first_phase, nxt_phase;
  logic              first_ok, has_next;
  logic [COL_W-1:0]  nxt_j;

  logic [GW_W-1:0]   w_eff;
  logic [GH_W-1:0]   h_eff;
  logic [GW_W:0]     col_nx;
  logic [GH_W-1:0]   row_nx;
  logic              end_row, end_frame, acc_in, start, load;

  logic [NB_W-1:0]   rd_k_q, rd_sel_q, sel_m1;
  logic              rd_v_q, rd_ok_q, row_ok, col_ok, re_prev;
  ofs_e              dr, dc;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [1:0]        rdata;
  cls_e              cls_q;
  logic [7:0]        mask_q;
  wall_hit_t         wh;
  logic [CODE_W-1:0] code;

  logic              out_valid_q, last_q, done_flag_q;
  logic [CODE_W-1:0] tile_code_q;
  seed_stat_t        stat;

  // effective geometry
  always_comb begin
    w_eff = gw_q;
    if (gw_q == '0) begin
      w_eff = GW_W'(1);
    end else if (gw_q > GW_W'(MAX_WIDTH)) begin
      w_eff = GW_W'(MAX_WIDTH);
    end
    h_eff = gh_q;
    if (gh_q == '0) begin
      h_eff = GH_W'(1);
    end else if (gh_q > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end
  end

  assign col_nx    = (GW_W+1)'(col_q) + 1'b1;
  assign row_nx    = GH_W'(row_q) + 1'b1;
  assign end_row   = col_nx >= {1'b0, w_eff};
  assign end_frame = end_row && (row_nx >= h_eff);
  assign in_stall_o = (state_q != ST_IDLE);
  assign acc_in    = in_valid_i && !in_stall_o;

  // first tile this cell releases
  always_comb begin
    first_ok    = 1'b1;
    first_phase = PH_FLUSH;
    if (row_q != '0 && col_q != '0) begin
      first_phase = PH_PREV_LEFT;
    end else if (row_q != '0 && end_row) begin
      first_phase = PH_PREV_CUR;
    end else if (!end_frame) begin
      first_ok = 1'b0;
    end
  end

  // tile after the one being emitted
  always_comb begin
    has_next  = 1'b0;
    nxt_phase = PH_FLUSH;
    nxt_j     = '0;
    case (phase_q)
      PH_PREV_LEFT: begin
        if (e_pc_q) begin
          has_next  = 1'b1;
          nxt_phase = PH_PREV_CUR;
        end else if (e_fr_q) begin
          has_next = 1'b1;
        end
      end
      PH_PREV_CUR: begin
        has_next = e_fr_q;
      end
      PH_FLUSH: begin
        has_next = (j_q != c_q);
        nxt_j    = j_q + 1'b1;
      end
      default: begin
        has_next = 1'b0;
      end
    endcase
  end

  // state machine
  always_comb begin
    state_d = state_q;
    start   = 1'b0;
    load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc_in && first_ok) begin
          state_d = ST_RUN;
          start   = 1'b1;
        end
      end
      ST_RUN: begin
        if (stat.done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load = 1'b1;
          if (has_next) begin
            state_d = ST_RUN;
            start   = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q    <= GW_W'(32);
      gh_q    <= GH_W'(32);
      sseed_q <= '0;
      ccnt_q  <= GW_W'(1);
      fcnt_q  <= GW_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GRID_WIDTH:  gw_q    <= cfg_data_i[GW_W-1:0];
        REG_GRID_HEIGHT: gh_q    <= cfg_data_i[GH_W-1:0];
        REG_START_SEED:  sseed_q <= cfg_data_i[SEED_W-1:0];
        REG_CEIL_COUNT:  ccnt_q  <= cfg_data_i[TEX_W-1:0];
        REG_FLOOR_COUNT: fcnt_q  <= cfg_data_i[TEX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // seed state
  always_comb begin
    seed_d = seed_q;
    if (cfg_we_i && cfg_reg_e'(cfg_index_i) == REG_START_SEED
        && col_q == '0 && row_q == '0) begin
      seed_d = cfg_data_i[SEED_W-1:0];
    end else if (load) begin
      seed_d = (!has_next && e_fr_q) ? sseed_q : stat.next_seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else begin
      seed_q <= seed_d;
    end
  end

  // raster counters and the pending tile list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      slot_q  <= '0;
      phase_q <= PH_FLUSH;
      j_q     <= '0;
      c_q     <= '0;
      eslot_q <= '0;
      rge1_q  <= 1'b0;
      rge2_q  <= 1'b0;
      e_pc_q  <= 1'b0;
      e_fr_q  <= 1'b0;
    end else if (acc_in) begin
      c_q     <= col_q;
      eslot_q <= slot_q;
      rge1_q  <= (row_q != '0);
      rge2_q  <= (row_q > ROW_W'(1));
      e_pc_q  <= (row_q != '0) && end_row;
      e_fr_q  <= end_frame;
      phase_q <= first_phase;
      j_q     <= '0;
      if (end_frame) begin
        col_q  <= '0;
        row_q  <= '0;
        slot_q <= '0;
      end else if (end_row) begin
        col_q  <= '0;
        row_q  <= row_q + 1'b1;
        slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end else if (load) begin
      phase_q <= nxt_phase;
      j_q     <= nxt_j;
    end
  end

  // window of the tile being emitted
  always_comb begin
    case (phase_q)
      PH_PREV_LEFT: ec = c_q - 1'b1;
      PH_PREV_CUR:  ec = c_q;
      default:      ec = j_q;
    endcase
    re_prev = (phase_q != PH_FLUSH);
    dr      = nb_row(rd_k_q);
    dc      = nb_col(rd_k_q);
    nb_back = re_prev ? 2'd1 : 2'd0;
    case (dr)
      OFS_MINUS: begin
        row_ok  = re_prev ? rge2_q : rge1_q;
        nb_back = nb_back + 2'd1;
      end
      OFS_PLUS: begin
        row_ok  = re_prev;
        nb_back = nb_back - 2'd1;
      end
      default: row_ok = 1'b1;
    endcase
    case (dc)
      OFS_MINUS: begin
        col_ok = (ec != '0);
        nb_c   = ec - 1'b1;
      end
      OFS_PLUS: begin
        col_ok = ((GW_W+1)'(ec) + 1'b1) < {1'b0, w_eff};
        nb_c   = ec + 1'b1;
      end
      default: begin
        col_ok = 1'b1;
        nb_c   = ec;
      end
    endcase
    nb_slot = slot_back(eslot_q, nb_back);
    raddr   = (row_ok && col_ok) ? slot_base(nb_slot) + ADDR_W'(nb_c) : '0;
  end

  assign waddr = slot_base(slot_q) + ADDR_W'(col_q);

  ntc_ram #(
    .WIDTH (2),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (acc_in),
    .waddr_i (waddr),
    .wdata_i (cell_class_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // one store read per cycle, center then the eight neighbors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_k_q <= NB_W'(NB_READS);
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= (state_q == ST_RUN) && (rd_k_q != NB_W'(NB_READS));
      if (start) begin
        rd_k_q <= '0;
      end else if (state_q == ST_RUN && rd_k_q != NB_W'(NB_READS)) begin
        rd_k_q <= rd_k_q + 1'b1;
      end
    end
  end

  assign sel_m1 = rd_sel_q - 1'b1;

  always_ff @(posedge clk_i) begin
    rd_sel_q <= rd_k_q;
    rd_ok_q  <= row_ok && col_ok;
    if (rd_v_q) begin
      if (rd_sel_q == '0) begin
        cls_q <= cls_e'(rdata);
      end else begin
        mask_q[sel_m1[2:0]] <= rd_ok_q && (cls_e'(rdata) == CLS_FLOOR);
      end
    end
  end

  ntc_seed u_seed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .seed_i      (seed_d),
    .ceil_cnt_i  (ccnt_q),
    .floor_cnt_i (fcnt_q),
    .stat_o      (stat)
  );

  // tile code
  always_comb begin
    wh = wall_lookup(mask_q);
    case (cls_q)
      CLS_FLOOR: code = {stat.floor_tex, 2'b00};
      CLS_CEIL:  code = {stat.ceil_tex, 2'b01};
      CLS_WALL:  code = wh.hit ? {2'b00, wh.list, 2'b10} : CODE_PLAIN;
      default:   code = CODE_PLAIN;
    endcase
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tile_code_q <= code;
      last_q      <= !has_next;
      done_flag_q <= (phase_q == PH_FLUSH) && (j_q == c_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tile_code_o   = tile_code_q;
  assign last_of_run_o = last_q;
  assign frame_done_o  = done_flag_q;

  `NTC_ASSERT(a_seed_done_in_run, stat.done |-> (state_q == ST_RUN), "seed unit done outside run")
  `NTC_ASSERT(a_put_holds, (state_q == ST_PUT) && out_valid_q && out_stall_i |=> (state_q == ST_PUT) && $stable(tile_code_q), "word overwritten while stalled")
  `NTC_ASSERT(a_done_is_last, out_valid_o && frame_done_o |-> last_of_run_o, "frame end word not last of run")
  `NTC_NEVER(a_reads_finished, (state_q == ST_PUT) && (rd_k_q != NB_W'(NB_READS)), "window reads still pending at hand-off")

endmodule
